@@ rtl/wer_pkg.sv @@
`default_nettype none

package wer_pkg;

  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned DataBits  = 32;
  localparam int unsigned CmdBits   = 2;
  localparam int unsigned IdxBits   = 2;
  localparam int unsigned CmpBits   = (TIME_BITS > DataBits) ? TIME_BITS : DataBits;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [DataBits-1:0]  data_t;
  typedef logic [CmpBits-1:0]   cmp_t;
  typedef logic [CmdBits-1:0]   cmd_t;
  typedef logic [IdxBits-1:0]   idx_t;

  typedef enum logic [CmdBits-1:0] {
    CMD_ADD   = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_RESET = 2'd2
  } cmd_e;

  typedef enum logic [IdxBits-1:0] {
    REG_EVENT_LIMIT   = 2'd0,
    REG_WINDOW_LENGTH = 2'd1,
    REG_PENALTY_WAIT  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    data_t event_limit;
    data_t window_length;
    data_t penalty_wait;
  } cfg_t;

  typedef struct packed {
    cmd_t  cmd;
    data_t amount;
    data_t now;
  } item_t;

  typedef struct packed {
    logic  allowed;
    data_t remaining;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/wer_if.sv @@
`default_nettype none

interface wer_in_if;
  logic            valid;
  logic            ready;
  wer_pkg::cmd_t   cmd;
  wer_pkg::data_t  amount;
  wer_pkg::data_t  now;

  modport source (output valid, output cmd, output amount, output now, input ready);
  modport sink   (input valid, input cmd, input amount, input now, output ready);
endinterface

interface wer_out_if;
  logic            valid;
  logic            ready;
  logic            allowed;
  wer_pkg::data_t  remaining;

  modport source (output valid, output allowed, output remaining, input ready);
  modport sink   (input valid, input allowed, input remaining, output ready);
endinterface

interface wer_cfg_if;
  logic            valid;
  logic            ready;
  wer_pkg::idx_t   index;
  wer_pkg::data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/wer_cfg.sv @@
`default_nettype none

module wer_cfg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_en_i,
  input  wire wer_pkg::idx_t  wr_idx_i,
  input  wire wer_pkg::data_t wr_data_i,
  output wer_pkg::cfg_t       cfg_o
);

  wer_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wer_pkg::cfg_reg_e'(wr_idx_i))
        wer_pkg::REG_EVENT_LIMIT:   cfg_d.event_limit   = wr_data_i;
        wer_pkg::REG_WINDOW_LENGTH: cfg_d.window_length = wr_data_i;
        wer_pkg::REG_PENALTY_WAIT:  cfg_d.penalty_wait  = wr_data_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/wer_step.sv @@
`default_nettype none

module wer_step (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire wer_pkg::item_t   item_i,
  input  wire wer_pkg::cfg_t    cfg_i,
  output wer_pkg::result_t      res_o
);

  logic           tracking_q, tracking_d;
  logic           penalized_q, penalized_d;
  wer_pkg::time_t window_start_q, window_start_d;
  wer_pkg::time_t penalty_start_q, penalty_start_d;
  wer_pkg::data_t event_count_q, event_count_d;

  always_comb begin
    wer_pkg::time_t           now_t;
    wer_pkg::time_t           win_elapsed;
    wer_pkg::time_t           pen_elapsed;
    logic                     win_restart;
    logic [wer_pkg::DataBits:0] sum;
    wer_pkg::data_t           base_count;

    now_t       = wer_pkg::time_t'(item_i.now);
    win_elapsed = now_t - window_start_q;
    pen_elapsed = now_t - penalty_start_q;
    win_restart = !tracking_q ||
                  (wer_pkg::cmp_t'(win_elapsed) >= wer_pkg::cmp_t'(cfg_i.window_length));
    base_count  = win_restart ? '0 : event_count_q;
    sum         = {1'b0, base_count} + {1'b0, item_i.amount};

    tracking_d      = tracking_q;
    penalized_d     = penalized_q;
    window_start_d  = window_start_q;
    penalty_start_d = penalty_start_q;
    event_count_d   = event_count_q;
    res_o.allowed   = 1'b1;

    unique case (wer_pkg::cmd_e'(item_i.cmd))
      wer_pkg::CMD_ADD: begin
        tracking_d      = 1'b1;
        window_start_d  = win_restart ? now_t : window_start_q;
        penalized_d     = win_restart ? 1'b0 : penalized_q;
        penalty_start_d = win_restart ? '0 : penalty_start_q;
        event_count_d   = sum[wer_pkg::DataBits] ? '1 : sum[wer_pkg::DataBits-1:0];
        if (event_count_d >= cfg_i.event_limit) begin
          penalized_d     = 1'b1;
          penalty_start_d = now_t;
        end
      end
      wer_pkg::CMD_CHECK: begin
        if (tracking_q && penalized_q && (event_count_q >= cfg_i.event_limit)) begin
          if (wer_pkg::cmp_t'(pen_elapsed) >= wer_pkg::cmp_t'(cfg_i.penalty_wait)) begin
            tracking_d      = 1'b0;
            penalized_d     = 1'b0;
            window_start_d  = '0;
            penalty_start_d = '0;
            event_count_d   = '0;
          end else begin
            res_o.allowed = 1'b0;
          end
        end
      end
      wer_pkg::CMD_RESET: begin
        tracking_d      = 1'b0;
        penalized_d     = 1'b0;
        window_start_d  = '0;
        penalty_start_d = '0;
        event_count_d   = '0;
      end
      default: begin
        res_o.allowed = 1'b1;
      end
    endcase

    if (penalized_d || (event_count_d >= cfg_i.event_limit)) begin
      res_o.remaining = '0;
    end else begin
      res_o.remaining = cfg_i.event_limit - event_count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracking_q      <= 1'b0;
      penalized_q     <= 1'b0;
      window_start_q  <= '0;
      penalty_start_q <= '0;
      event_count_q   <= '0;
    end else if (fire_i) begin
      tracking_q      <= tracking_d;
      penalized_q     <= penalized_d;
      window_start_q  <= window_start_d;
      penalty_start_q <= penalty_start_d;
      event_count_q   <= event_count_d;
    end
  end

  a_pen_implies_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    penalized_q |-> tracking_q)
    else $error("penalized without tracking");

  a_reset_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.cmd == wer_pkg::CMD_RESET) |=> (!tracking_q && event_count_q == '0))
    else $error("reset command left state");

  a_add_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.cmd == wer_pkg::CMD_ADD) |=> tracking_q)
    else $error("add did not start tracking");

  a_deny_only_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !res_o.allowed) |-> (item_i.cmd == wer_pkg::CMD_CHECK && penalized_q))
    else $error("deny outside a penalized check");

endmodule

`default_nettype wire

@@ rtl/windowed_event_rate_limiter.sv @@
// Windowed event rate limiter with penalty hold-off.
// Channels: in_i takes one beat per command (cmd, amount, now); out_o gives
// exactly one beat per command (allowed, remaining), in order; cfg_i writes
// event_limit (index 0), window_length (1) or penalty_wait (2) and is always
// ready; other indexes are ignored. Write configuration only while idle.
// Path: a command accepted from in_i sits in the input register until the
// result register can take it; it is then evaluated against the limiter state
// and lands in the result register, from which its result beat is offered.
// Throughput: one command per cycle while out_o.ready is high; the state
// update of one command and the evaluation of the next meet in the same
// cycle; the compare, add and subtract between the two registers set the pace.
// Reset: clears the configuration, the limiter state and both valid flags to
// zero; the limiter is not tracking and both pipeline stages are empty.
// Stall: while out_o.ready is low the result holds and the input register can
// still take one more beat; in_i.ready drops once both are full.
`default_nettype none

module windowed_event_rate_limiter (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wer_in_if.sink    in_i,
  wer_out_if.source out_o,
  wer_cfg_if.sink   cfg_i
);

  logic              in_valid_q;
  wer_pkg::item_t    in_item_q;
  logic              out_valid_q;
  wer_pkg::result_t  out_res_q;
  wer_pkg::result_t  step_res;
  wer_pkg::cfg_t     cfg;
  logic              advance;
  logic              fire;
  logic              in_take;

  assign advance     = !out_valid_q || out_o.ready;
  assign fire        = in_valid_q && advance;
  assign in_i.ready  = !in_valid_q || advance;
  assign in_take     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  wer_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  wer_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= '{cmd: in_i.cmd, amount: in_i.amount, now: in_i.now};
    end
    if (fire) begin
      out_res_q <= step_res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.allowed   = out_res_q.allowed;
  assign out_o.remaining = out_res_q.remaining;

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while both stages full");

  a_fire_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("evaluated beat not presented");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.ready && !in_valid_q) |=> !out_valid_q)
    else $error("result beat repeated");

endmodule

`default_nettype wire

@@ tb/sv/limiter_verdict_check.sv @@
`timescale 1ns / 1ps

module limiter_verdict_check
  import wer_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wer_in_if         cmd_bus,
  wer_out_if        verdict_bus,
  wer_cfg_if        cfg_bus,
  output int        errors_o,
  output int        pending_o
);

  data_t lim_events;
  data_t lim_window;
  data_t lim_wait;

  logic  tracking;
  time_t window_origin;
  data_t event_total;
  logic  penalized;
  time_t penalty_origin;

  result_t verdicts_due[$];
  int      mismatches;
  int      beats_seen;

  function automatic void clear_limiter();
    tracking       = 1'b0;
    window_origin  = '0;
    event_total    = '0;
    penalized      = 1'b0;
    penalty_origin = '0;
  endfunction

  function automatic result_t predict_verdict(item_t cmd_beat);
    result_t     verdict;
    logic [32:0] sum;
    verdict.allowed = 1'b1;
    case (cmd_beat.cmd)
      CMD_ADD: begin
        if (!tracking || time_t'(cmd_beat.now - window_origin) >= lim_window) begin
          clear_limiter();
        end
        sum = {1'b0, event_total} + {1'b0, cmd_beat.amount};
        event_total = sum[32] ? '1 : sum[31:0];
        if (!tracking) begin
          tracking      = 1'b1;
          window_origin = cmd_beat.now;
        end
        if (event_total >= lim_events) begin
          penalized      = 1'b1;
          penalty_origin = cmd_beat.now;
        end
      end
      CMD_CHECK: begin
        if (tracking && event_total >= lim_events && penalized) begin
          if (time_t'(cmd_beat.now - penalty_origin) >= lim_wait) begin
            clear_limiter();
          end else begin
            verdict.allowed = 1'b0;
          end
        end
      end
      CMD_RESET: begin
        clear_limiter();
      end
      default: begin
      end
    endcase
    verdict.remaining = (penalized || event_total >= lim_events) ? '0 : lim_events - event_total;
    return verdict;
  endfunction

  task automatic report_mismatch(string what, data_t got, data_t want);
    $display("[%0t] result beat %0d: %s got %0h, expected %0h", $time, beats_seen, what,
             got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      lim_events = '0;
      lim_window = '0;
      lim_wait   = '0;
      clear_limiter();
      verdicts_due.delete();
      mismatches = 0;
      beats_seen = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (verdict_bus.valid && verdict_bus.ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("unexpected beat, remaining", verdict_bus.remaining, '0);
        end else begin
          want = verdicts_due.pop_front();
          if (verdict_bus.allowed !== want.allowed) begin
            report_mismatch("allowed", data_t'(verdict_bus.allowed), data_t'(want.allowed));
          end
          if (verdict_bus.remaining !== want.remaining) begin
            report_mismatch("remaining", verdict_bus.remaining, want.remaining);
          end
        end
        beats_seen++;
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        verdicts_due.push_back(predict_verdict('{cmd: cmd_bus.cmd, amount: cmd_bus.amount,
                                                 now: cmd_bus.now}));
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_EVENT_LIMIT:   lim_events = cfg_bus.data;
          REG_WINDOW_LENGTH: lim_window = cfg_bus.data;
          REG_PENALTY_WAIT:  lim_wait   = cfg_bus.data;
          default: begin
          end
        endcase
      end
      errors_o  <= mismatches;
      pending_o <= verdicts_due.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import wer_pkg::*;

  localparam int    PHASES      = 8;
  localparam int    PHASE_ITEMS = 230;
  localparam int    CYCLE_LIMIT = 1000000;
  localparam int    HOLD_CYCLES = 300;
  localparam cmd_t  CMD_UNUSED  = 2'd3;
  localparam idx_t  REG_UNUSED  = 2'd3;
  localparam data_t ALL_ONES    = 32'hFFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni;

  wer_in_if  cmd_bus ();
  wer_out_if verdict_bus ();
  wer_cfg_if cfg_bus ();

  int mismatches;
  int verdicts_pending;
  int cycles = 0;
  bit steady;
  bit hold_req;

  data_t       phase_limit[PHASES]  = '{4, 1, 0, 16, ALL_ONES, 0, 8, 0};
  data_t       phase_window[PHASES] = '{20, 5, 10, 50, ALL_ONES, 0, 1, 0};
  data_t       phase_wait[PHASES]   = '{10, 3, 5, 30, ALL_ONES, 0, 0, 0};
  int unsigned phase_step[PHASES]   = '{4, 2, 3, 6, 8, 2, 1, 5};
  int unsigned phase_amount[PHASES] = '{2, 1, 1, 5, 3, 2, 3, 4};

  always #1 clk_i = ~clk_i;

  windowed_event_rate_limiter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_bus),
    .out_o  (verdict_bus),
    .cfg_i  (cfg_bus)
  );

  limiter_verdict_check verdict_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_bus     (cmd_bus),
    .verdict_bus (verdict_bus),
    .cfg_bus     (cfg_bus),
    .errors_o    (mismatches),
    .pending_o   (verdicts_pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[windowed_event_rate_limiter] ERROR");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 65) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(cmd_t op, data_t amt, data_t stamp);
    int unsigned gap;
    cmd_bus.valid  <= 1'b1;
    cmd_bus.cmd    <= op;
    cmd_bus.amount <= amt;
    cmd_bus.now    <= stamp;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(idx_t idx, data_t value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    cmd_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (verdicts_pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // result channel back-pressure
  initial begin
    bit          hold_served;
    int unsigned roll;
    hold_served = 1'b0;
    verdict_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        verdict_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (steady) begin
        verdict_bus.ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          verdict_bus.ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk_i);
        end else begin
          verdict_bus.ready <= (roll < 75);
        end
      end
    end
  end

  initial begin
    int unsigned p;
    int unsigned n;
    int unsigned roll;
    data_t       stamp;
    data_t       amt;
    cmd_t        op;

    steady         = 1'b0;
    hold_req       = 1'b0;
    rst_ni         <= 1'b0;
    cmd_bus.valid  <= 1'b0;
    cmd_bus.cmd    <= CMD_ADD;
    cmd_bus.amount <= '0;
    cmd_bus.now    <= '0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= REG_EVENT_LIMIT;
    cfg_bus.data   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(REG_EVENT_LIMIT, 5);
    write_reg(REG_WINDOW_LENGTH, 100);
    write_reg(REG_PENALTY_WAIT, 50);
    write_reg(REG_UNUSED, ALL_ONES);

    send_item(CMD_CHECK, 0, 1000);
    send_item(CMD_ADD, 2, 1000);
    send_item(CMD_ADD, 0, 1010);
    send_item(CMD_CHECK, 0, 1020);
    send_item(CMD_ADD, 3, 1030);
    send_item(CMD_CHECK, 0, 1040);
    send_item(CMD_CHECK, 0, 1080);
    send_item(CMD_ADD, ALL_ONES, 1090);
    send_item(CMD_ADD, ALL_ONES, 1091);
    send_item(CMD_UNUSED, ALL_ONES, 1092);
    send_item(CMD_RESET, 0, 1093);
    send_item(CMD_ADD, 1, 1100);
    send_item(CMD_ADD, 1, 1200);
    send_item(CMD_ADD, 1, 50);
    send_item(CMD_CHECK, 0, ALL_ONES);
    send_item(CMD_ADD, 0, ALL_ONES);
    send_item(CMD_RESET, 0, 0);
    send_item(CMD_ADD, 3, 0);
    wait_idle();

    // lower the limit below the running count
    write_reg(REG_EVENT_LIMIT, 2);
    send_item(CMD_CHECK, 0, 10);
    send_item(CMD_ADD, 0, 11);
    wait_idle();

    write_reg(REG_EVENT_LIMIT, 0);
    write_reg(REG_WINDOW_LENGTH, 0);
    write_reg(REG_PENALTY_WAIT, ALL_ONES);
    send_item(CMD_RESET, 0, 20);
    send_item(CMD_ADD, 0, 20);
    send_item(CMD_CHECK, 0, 21);
    send_item(CMD_CHECK, 0, 19);

    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p == PHASES - 1) begin
        phase_limit[p]  = $urandom_range(0, 20);
        phase_window[p] = $urandom_range(0, 40);
        phase_wait[p]   = $urandom_range(0, 40);
      end
      write_reg(REG_EVENT_LIMIT, phase_limit[p]);
      write_reg(REG_WINDOW_LENGTH, phase_window[p]);
      write_reg(REG_PENALTY_WAIT, phase_wait[p]);
      stamp = $urandom;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
        if (p == 1 && n == 40) hold_req = 1'b1;

        roll = $urandom_range(0, 99);
        if (roll < 80) begin
          stamp += $urandom_range(0, phase_step[p]);
        end else if (roll < 97) begin
          if (roll >= 95) stamp = $urandom;
        end else begin
          stamp -= $urandom_range(1, 5);
        end

        roll = $urandom_range(0, 99);
        if (roll < 70) amt = $urandom_range(0, phase_amount[p]);
        else if (roll < 85) amt = $urandom;
        else if (roll < 92) amt = ALL_ONES;
        else amt = '0;

        roll = $urandom_range(0, 99);
        if (roll < 48) op = CMD_ADD;
        else if (roll < 88) op = CMD_CHECK;
        else if (roll < 95) op = CMD_RESET;
        else op = CMD_UNUSED;

        send_item(op, amt, stamp);
      end
    end

    steady = 1'b0;
    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[windowed_event_rate_limiter] OK");
    end else begin
      $display("[windowed_event_rate_limiter] ERROR");
    end
    $finish;
  end

endmodule
